@@ rtl/iq_block_power_dbm_meter_assert.svh @@
// assertion macros for the iq block power meter
// no dependencies; included by the modules that carry assertions
`ifndef IQ_BLOCK_POWER_DBM_METER_ASSERT_SVH
`define IQ_BLOCK_POWER_DBM_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define IQPM_ASSERT_PROP(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) \
   prop) else $error("iqpm property failed");
`define IQPM_ASSERT_ALWAYS(lbl, expr) lbl: assert property (@(posedge clock) disable iff (reset) \
   (expr)) else $error("iqpm invariant failed");
`else
`define IQPM_ASSERT_PROP(lbl, prop)
`define IQPM_ASSERT_ALWAYS(lbl, expr)
`endif
`endif

@@ rtl/iqpm_pkg.sv @@
// package for the iq block power meter: constants, fsm state type, command/status structs
// no dependencies
package iqpm_pkg;

   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int FRAC_BITS       = 24;
   localparam int MANT_W          = 31;
   localparam logic [29:0] FULL_SCALE_SQ = 30'd1073676289;
   localparam logic signed [26:0] TEN_LOG10_2_Q24 = 27'sd50504453;
   localparam logic signed [63:0] POWER_MIN = -64'sd140000;
   localparam logic signed [63:0] POWER_MAX = 64'sd110000;
   localparam int CSR_DATA_W  = 9;
   localparam int RSP_DATA_W  = 40;

   typedef enum logic {
      CSR_FULL_SCALE = 1'b0,
      CSR_GAIN       = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_ACC,
      ST_PROD,
      ST_CHK,
      ST_LOAD,
      ST_NORM,
      ST_SQ,
      ST_RED,
      ST_STORE,
      ST_SCALE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic prod;
      logic load_x;
      logic sel;
      logic norm;
      logic sq;
      logic red;
      logic store;
      logic scale;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic msb;
      logic out_free;
   } status_type;

endpackage

@@ rtl/iq_block_power_dbm_meter.sv @@
// top level of the iq block power meter: controller plus datapath
// depends on iqpm_pkg, iqpm_ctrl, iqpm_dp
//
// usage:
// - req channel takes one signed 16-bit i or q sample per word in req_tdata,
//   req_tlast marks the final sample of a measurement block
// - samples are accepted one per cycle while a block accumulates
// - after the last sample the block computes the level: product and zero check, then two
//   log2 passes of (load + normalize shift + square/reduce steps + store), then scale
//   and output load; a zero sum goes straight to the output load; the normalize shift
//   depends on the operand size; req_tready is low then
// - both passes share the log2 unit (one squaring multiplier, one fraction bit per
//   square/reduce step)
// - rsp carries one word per block: power in 1/256 dBm, zero-power and overflow
//   flags and the sample count; it sits in an output register, so the next block
//   is accepted while the result waits
// - if rsp is stalled when the next result is done, the block waits for it
// - csr channel writes full_scale_dbm (index 0) or total_gain_db (index 1),
//   always ready; write only while idle
// - synchronous reset clears accumulators, the csr registers, the fsm state and the output valid
module iq_block_power_dbm_meter #(
   parameter int MAX_SAMPLES = iqpm_pkg::MAX_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // sample[15:0]
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // power_q8[18:0], zero_power[19], overflow[20], sample_count[37:21], zero pad
   output logic [iqpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [iqpm_pkg::CSR_DATA_W-1:0] csr_data
);
   import iqpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   iqpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   iqpm_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ rtl/iqpm_ctrl.sv @@
// controller fsm for the iq block power meter
// depends on iqpm_pkg and iq_block_power_dbm_meter_assert.svh
`include "iq_block_power_dbm_meter_assert.svh"
module iqpm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  iqpm_pkg::status_type status,
   output iqpm_pkg::cmd_type    cmd
);
   import iqpm_pkg::*;

   state_type  state_ff, state_in;
   logic       pass_ff, pass_in;
   logic [4:0] bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         pass_ff  <= 1'b0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_ACC: begin
            if (req_tvalid && req_tlast) state_in = ST_PROD;
         end
         ST_PROD: state_in = ST_CHK;
         ST_CHK: begin
            pass_in  = 1'b0;
            state_in = status.sum_zero ? ST_FIN : ST_LOAD;
         end
         ST_LOAD: state_in = ST_NORM;
         ST_NORM: begin
            bit_in = '0;
            if (status.msb) state_in = ST_SQ;
         end
         ST_SQ: state_in = ST_RED;
         ST_RED: begin
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'(FRAC_BITS - 1)) state_in = ST_STORE;
            else state_in = ST_SQ;
         end
         ST_STORE: begin
            if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_FIN;
         ST_FIN: begin
            if (status.out_free) state_in = ST_ACC;
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.sel    = pass_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_PROD:  cmd.prod = 1'b1;
         ST_CHK:   cmd.prod = 1'b0;
         ST_LOAD:  cmd.load_x = 1'b1;
         ST_NORM:  cmd.norm = 1'b1;
         ST_SQ:    cmd.sq = 1'b1;
         ST_RED:   cmd.red = 1'b1;
         ST_STORE: cmd.store = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_FIN:   cmd.out_load = status.out_free;
         default:  cmd = '0;
      endcase
   end

   `IQPM_ASSERT_ALWAYS(a_bit_range, bit_ff <= 5'(FRAC_BITS))
   `IQPM_ASSERT_PROP(a_last_stops, (req_tvalid && req_tready && req_tlast) |=> !req_tready)

endmodule

@@ rtl/iqpm_dp.sv @@
// datapath for the iq block power meter: accumulators, shared log2 unit, scaling, result register
// depends on iqpm_pkg and iq_block_power_dbm_meter_assert.svh
`include "iq_block_power_dbm_meter_assert.svh"
module iqpm_dp #(
   parameter int MAX_SAMPLES = iqpm_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [15:0]                           req_tdata,
   input  logic                                  csr_valid,
   input  logic                                  csr_index,
   input  logic [iqpm_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [iqpm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  iqpm_pkg::cmd_type                     cmd,
   output iqpm_pkg::status_type                  status
);
   import iqpm_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int W     = CNT_W + 30;
   localparam int PW    = $clog2(W);
   localparam int LGW   = PW + FRAC_BITS;
   localparam int DW    = LGW + 1;
   localparam int MW    = DW + 27;

   logic signed [8:0]  fs_ff, gain_ff;
   logic [30:0]        sq_ff;
   logic               sqv_ff;
   logic [W-1:0]       sum_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               ovf_ff;
   logic [W-1:0]       prod_ff;
   logic [W-1:0]       x_ff;
   logic [PW-1:0]      p_ff;
   logic [MANT_W-1:0]  m_ff;
   logic [61:0]        msq_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [LGW-1:0]     ls_ff;
   logic signed [DW-1:0] d_ff;
   logic signed [MW-1:0] mul_ff;
   logic               vld_ff;
   logic [RSP_DATA_W-1:0] data_ff;

   logic signed [31:0] sq_full;
   logic [LGW-1:0]     lg;
   logic [31:0]        t;
   logic signed [9:0]  diff;
   logic signed [63:0] v;
   logic signed [63:0] pw;
   logic signed [18:0] power;
   logic [CNT_W+16:0]  cnt_ext;
   logic               zero;

   assign sq_full = $signed(req_tdata) * $signed(req_tdata);
   assign lg      = {p_ff, frac_ff};
   assign t       = msq_ff[61:30];
   assign diff    = 10'(fs_ff) - 10'(gain_ff);
   assign v       = 64'(mul_ff) + (64'(diff) <<< 48);
   assign pw      = (v + 64'sd549755813888) >>> 40;
   assign zero    = (sum_ff == '0);
   assign cnt_ext = (CNT_W + 17)'(cnt_ff);

   always_comb begin
      if (zero || pw < POWER_MIN) power = 19'(POWER_MIN);
      else if (pw > POWER_MAX) power = 19'(POWER_MAX);
      else power = pw[18:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff   <= '0;
         gain_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_FULL_SCALE) fs_ff <= $signed(csr_data);
         else gain_ff <= $signed(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.out_load) begin
         sqv_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sqv_ff <= 1'b0;
         if (sqv_ff) sum_ff <= sum_ff + W'(sq_ff);
         if (cmd.accept) begin
            if (cnt_ff < CNT_W'(MAX_SAMPLES)) begin
               sqv_ff <= 1'b1;
               cnt_ff <= cnt_ff + CNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) sq_ff <= sq_full[30:0];
      if (cmd.prod) prod_ff <= W'(cnt_ff) * W'(FULL_SCALE_SQ);
      if (cmd.load_x) begin
         x_ff <= cmd.sel ? prod_ff : sum_ff;
         p_ff <= PW'(W - 1);
      end else if (cmd.norm) begin
         if (x_ff[W-1]) begin
            m_ff    <= x_ff[W-1 -: MANT_W];
            frac_ff <= '0;
         end else begin
            x_ff <= {x_ff[W-2:0], 1'b0};
            p_ff <= p_ff - PW'(1);
         end
      end
      if (cmd.sq) msq_ff <= m_ff * m_ff;
      if (cmd.red) begin
         if (t[31]) begin
            m_ff    <= t[31:1];
            frac_ff <= {frac_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            m_ff    <= t[30:0];
            frac_ff <= {frac_ff[FRAC_BITS-2:0], 1'b0};
         end
      end
      if (cmd.store) begin
         if (!cmd.sel) ls_ff <= lg;
         else d_ff <= $signed({1'b0, ls_ff}) - $signed({1'b0, lg});
      end
      if (cmd.scale) mul_ff <= MW'(d_ff) * MW'(TEN_LOG10_2_Q24);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.out_load) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) data_ff <= {2'b00, cnt_ext[16:0], ovf_ff, zero, power};
   end

   assign rsp_tvalid      = vld_ff;
   assign rsp_tdata       = data_ff;
   assign status.sum_zero = zero;
   assign status.msb      = x_ff[W-1];
   assign status.out_free = !vld_ff || rsp_tready;

   `IQPM_ASSERT_ALWAYS(a_cnt_cap, cnt_ff <= CNT_W'(MAX_SAMPLES))
   `IQPM_ASSERT_PROP(a_ovf_full, ovf_ff |-> (cnt_ff == CNT_W'(MAX_SAMPLES)))

endmodule

@@ sim/tb_iq_block_power_dbm_meter.sv @@
// testbench for iq_block_power_dbm_meter: streams sample blocks with random gaps and stalls
// and checks each power result against a predictor of the log2/dB math; uses iqpm_pkg
`timescale 1ns / 100ps

module tb_iq_block_power_dbm_meter;
   import iqpm_pkg::*;

   localparam int MAX_CNT = 65536;

   typedef struct {
      logic signed [18:0] power_q8;
      logic               zero_power;
      logic               overflow;
      logic [16:0]        sample_count;
   } level_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_FULL_SCALE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   level_type level_q[$];
   longint unsigned acc_sq_sum;
   int unsigned acc_count;
   bit acc_ovf;
   logic signed [8:0] fs_dbm, gain_db;
   int errors = 0;
   bit no_idle = 0;
   int rsp_wait = 0;

   iq_block_power_dbm_meter u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint log2_q24(longint unsigned x);
      int p;
      longint unsigned m, frac;
      p = 0;
      frac = 0;
      if (x == 0) x = 1;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'd2147483648) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(p) << 24) | longint'(frac);
   endfunction

   function automatic void accumulate_sample(logic signed [15:0] s, logic l);
      level_type r;
      longint d, v, pw;
      if (acc_count < MAX_CNT) begin
         acc_sq_sum += longint'(s) * longint'(s);
         acc_count++;
      end else begin
         acc_ovf = 1;
      end
      if (!l) return;
      r.zero_power = (acc_sq_sum == 0 || acc_count == 0);
      if (r.zero_power) begin
         pw = -140000;
      end else begin
         d = log2_q24(acc_sq_sum) - log2_q24(longint'(acc_count) * 64'd1073676289);
         v = d * 64'sd50504453 + (longint'(fs_dbm) - longint'(gain_db)) * (64'sd1 <<< 48);
         pw = (v + (64'sd1 <<< 39)) >>> 40;
         if (pw < -140000) pw = -140000;
         if (pw > 110000) pw = 110000;
      end
      r.power_q8 = pw[18:0];
      r.overflow = acc_ovf;
      r.sample_count = acc_count[16:0];
      level_q.push_back(r);
      acc_sq_sum = 0;
      acc_count = 0;
      acc_ovf = 0;
   endfunction

   // result side: random stall before each word, compare on handshake
   always @(posedge clock) begin
      level_type e;
      int nxt;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         nxt = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            if (level_q.size() == 0) begin
               $display("%0t unexpected word: expected none actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               e = level_q.pop_front();
               if (rsp_tdata[18:0] !== e.power_q8 || rsp_tdata[19] !== e.zero_power ||
                   rsp_tdata[20] !== e.overflow || rsp_tdata[37:21] !== e.sample_count) begin
                  $display("%0t power %0d zero %b ovf %b count %0d expected, actual %0d %b %b %0d",
                     $time, e.power_q8, e.zero_power, e.overflow, e.sample_count,
                     $signed(rsp_tdata[18:0]), rsp_tdata[19], rsp_tdata[20], rsp_tdata[37:21]);
                  errors++;
               end
            end
            nxt = no_idle ? 0 : $urandom_range(0, 5);
         end else if (nxt > 0) begin
            nxt--;
         end
         rsp_wait = nxt;
         rsp_tready <= (nxt == 0);
      end
   end

   task automatic send_sample(logic signed [15:0] s, logic l);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      accumulate_sample(s, l);
   endtask

   task automatic write_csr(csr_index_type idx, logic signed [8:0] val);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FULL_SCALE) fs_dbm = val;
      else gain_db = val;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (level_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_levels(logic signed [8:0] fs, logic signed [8:0] g);
      wait_idle();
      write_csr(CSR_FULL_SCALE, fs);
      write_csr(CSR_GAIN, g);
   endtask

   function automatic logic signed [15:0] rand_sample();
      logic [15:0] r;
      r = 16'($urandom);
      case ($urandom_range(0, 3))
         0: return r;
         1: return $signed(r) >>> $urandom_range(1, 15);
         2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
         default: return $signed(r) >>> 12;
      endcase
   endfunction

   task automatic test_extremes();
      set_levels(9'sd0, 9'sd0);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b1);
   endtask

   task automatic test_zero_block();
      send_sample(16'sd0, 1'b1);
      repeat (4) send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
   endtask

   task automatic test_clamps();
      set_levels(9'sd255, 9'sh100);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sd1, 1'b1);
      set_levels(9'sh100, 9'sd255);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sd3, 1'b1);
      set_levels(9'sd200, -9'sd200);
      send_sample(16'sd100, 1'b1);
      set_levels(-9'sd200, 9'sd200);
      send_sample(16'sh8000, 1'b1);
   endtask

   task automatic test_long_block();
      set_levels(9'sd13, 9'sd30);
      no_idle = 1;
      for (int i = 0; i < 60; i++) send_sample(rand_sample(), i == 59);
      for (int i = 0; i < 60; i++) send_sample(16'sh8000, i == 59);
      no_idle = 0;
   endtask

   task automatic test_random();
      int len, sent;
      sent = 0;
      for (int phase = 0; phase < 5; phase++) begin
         set_levels(9'($urandom), 9'($urandom));
         no_idle = (phase == 2);
         while (sent < 120 * (phase + 1)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_sample(($urandom_range(0, 15) == 0) ? 16'sd0 : rand_sample(), i == len - 1);
               sent++;
            end
         end
      end
      no_idle = 0;
   endtask

   initial begin
      acc_sq_sum = 0;
      acc_count = 0;
      acc_ovf = 0;
      fs_dbm = 0;
      gain_db = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_zero_block();
      test_clamps();
      test_long_block();
      test_random();
      wait_idle();
      if (errors == 0)
         $display("iq_block_power_dbm_meter: match");
      else
         $display("iq_block_power_dbm_meter: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("iq_block_power_dbm_meter: mismatch");
      $finish;
   end

endmodule
